// File: sv/rrh_pkg.sv
`default_nettype none

package rrh_pkg;

  localparam int unsigned ANGLE_W = 13;
  localparam int unsigned SIN_W   = 15;

  // Pi in unsigned Q60, used only when the sine table is built.
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // round(32767 * sin(th)) for an angle th in Q60 radians, evaluated at
  // elaboration only. The Taylor series is summed in Q60, far finer than the
  // final rounding.
  function automatic logic [SIN_W-1:0] sin_q15(logic [63:0] th);
    logic [63:0] th2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] scaled;
    th2  = mul_q60(th, th);
    term = th;
    sum  = th;
    for (int n = 1; n < 40; n++) begin
      if (term != 64'd0) begin
        term = mul_q60(term, th2) / 64'((2 * n) * (2 * n + 1));
        if (n[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    scaled = (sum >> 16) * 64'd32767 + (64'd1 << 43);
    return scaled[58:44];
  endfunction

endpackage

`default_nettype wire

// File: sv/rrh_req_if.sv
`default_nettype none

interface rrh_req_if #(
  parameter int unsigned COORD_WIDTH = 24
);
  import rrh_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] rect_left;
  logic signed [COORD_WIDTH-1:0] rect_top;
  logic        [COORD_WIDTH-2:0] rect_width;
  logic        [COORD_WIDTH-2:0] rect_height;
  logic        [ANGLE_W-1:0]     rotation_angle;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;

  modport source (
    output valid, rect_left, rect_top, rect_width, rect_height, rotation_angle,
           point_x, point_y,
    input  ready
  );

  modport sink (
    input  valid, rect_left, rect_top, rect_width, rect_height, rotation_angle,
           point_x, point_y,
    output ready
  );

endinterface

`default_nettype wire

// File: sv/rrh_res_if.sv
`default_nettype none

interface rrh_res_if;

  logic valid;
  logic ready;
  logic inside_res;

  modport source (
    output valid, inside_res,
    input  ready
  );

  modport sink (
    input  valid, inside_res,
    output ready
  );

endinterface

`default_nettype wire

// File: sv/rotated_rect_point_hit_test_unit.sv
`default_nettype none

// Point-in-rotated-rectangle test. Each request carries a rectangle (signed
// Q16.8 corner, width and height), a rotation angle in 1/ANGLE_STEPS_PER_DEGREE
// degree steps and a query point; the point is rotated about the rectangle
// center and one result bit says whether it falls in left < x <= left+width
// and top < y <= top+height. Arithmetic is exact after the Q1.15 sine lookup.
// The unit is a six-stage pipeline: a request is taken every cycle unless
// every stage is full and the result is not taken. The stages are
// the input register, the angle-to-quadrant split, the quadrant correction, the
// registered sine table lookup (90*ANGLE_STEPS_PER_DEGREE+1 entries, two read
// ports), the four rotation products and the final sums and bound compares. A
// stalled result holds back only the unbroken run of full stages behind it.

module rotated_rect_point_hit_test_unit #(
  parameter int unsigned COORD_WIDTH            = 24,
  parameter int unsigned ANGLE_STEPS_PER_DEGREE = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rrh_req_if.sink       req_i,
  rrh_res_if.source     res_o
);
  import rrh_pkg::*;

  localparam int unsigned CW      = COORD_WIDTH;
  localparam int unsigned DW      = CW + 3;          // doubled center offsets
  localparam int unsigned TW      = SIN_W + 1;       // signed sine/cosine
  localparam int unsigned PW      = DW + TW;         // rotation products
  localparam int unsigned SW      = PW + 1;          // rotated coordinates
  localparam int unsigned Quarter = 90 * ANGLE_STEPS_PER_DEGREE;
  localparam int unsigned RW      = $clog2(Quarter + 1);
  localparam int unsigned Shift   = ANGLE_W + $clog2(Quarter);
  localparam int unsigned MW      = ANGLE_W + 1;
  localparam logic [MW-1:0]      Recip     = MW'((64'd1 << Shift) / Quarter);
  localparam logic [ANGLE_W:0]   QuarterA  = (ANGLE_W + 1)'(Quarter);
  localparam logic [RW-1:0]      QuarterR  = RW'(Quarter);
  localparam int unsigned NStage = 6;

  // Stage handshake: a stage loads when it is empty or the next one moves.
  logic [NStage-1:0] vld_q;
  logic [NStage-1:0] adv;

  always_comb begin
    adv[NStage-1] = !vld_q[NStage-1] || res_o.ready;
    for (int k = NStage - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign req_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= req_i.valid;
      end
      for (int k = 1; k < NStage; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 0: input register.
  logic signed [CW-1:0]      left0_q, top0_q, px0_q, py0_q;
  logic        [CW-2:0]      w0_q, h0_q;
  logic        [ANGLE_W-1:0] ang0_q;

  // Stage 1: quotient estimate and center offsets.
  logic [ANGLE_W+MW-1:0]     qprod;
  logic [ANGLE_W-1:0]        q1_d, q1_q, ang1_q;
  logic signed [DW-1:0]      dx1_d, dy1_d, dx1_q, dy1_q;
  logic [CW-2:0]             w1_q, h1_q;

  // Stage 2: corrected remainder and quadrant.
  logic [ANGLE_W:0]          qmul, rem0;
  logic [RW-1:0]             rem2_d, rem2_q;
  logic [ANGLE_W-1:0]        qfix;
  quad_e                     quad2_q, quad3_q;
  logic signed [DW-1:0]      dx2_q, dy2_q, dx3_q, dy3_q;
  logic [CW-2:0]             w2_q, h2_q, w3_q, h3_q, w4_q, h4_q;

  // Stage 3: sine table outputs.
  logic [SIN_W-1:0]          tab_a, tab_b;

  // Stage 4: products.
  logic signed [TW-1:0]      sin_v, cos_v, tab_a_s, tab_b_s;
  logic signed [PW-1:0]      pxc_q, pys_q, pyc_q, pxs_q;

  // Stage 5: result.
  logic signed [SW-1:0]      rx, ry, lim_x, lim_y;
  logic                      inside_d, inside_q;

  always_comb begin
    qprod = (ANGLE_W + MW)'(ang0_q) * (ANGLE_W + MW)'(Recip);
    q1_d  = ANGLE_W'(qprod >> Shift);
    dx1_d = (DW'(px0_q) <<< 1) - (DW'(left0_q) <<< 1) - $signed(DW'(w0_q));
    dy1_d = (DW'(py0_q) <<< 1) - (DW'(top0_q) <<< 1) - $signed(DW'(h0_q));
  end

  // The reciprocal estimate is at most one low; one compare fixes it.
  always_comb begin
    qmul = (ANGLE_W + 1)'(q1_q * QuarterA);
    rem0 = {1'b0, ang1_q} - qmul;
    if (rem0 >= QuarterA) begin
      rem2_d = RW'(rem0 - QuarterA);
      qfix   = q1_q + 1'b1;
    end else begin
      rem2_d = RW'(rem0);
      qfix   = q1_q;
    end
  end

  rrh_sin_rom #(
    .ANGLE_STEPS_PER_DEGREE(ANGLE_STEPS_PER_DEGREE)
  ) u_sin_rom (
    .clk_i   (clk_i),
    .en_i    (adv[3]),
    .addr_a_i(rem2_q),
    .addr_b_i(QuarterR - rem2_q),
    .data_a_o(tab_a),
    .data_b_o(tab_b)
  );

  always_comb begin
    tab_a_s = $signed({1'b0, tab_a});
    tab_b_s = $signed({1'b0, tab_b});
    unique case (quad3_q)
      QUAD_0: begin
        sin_v = tab_a_s;
        cos_v = tab_b_s;
      end
      QUAD_1: begin
        sin_v = tab_b_s;
        cos_v = -tab_a_s;
      end
      QUAD_2: begin
        sin_v = -tab_a_s;
        cos_v = -tab_b_s;
      end
      QUAD_3: begin
        sin_v = -tab_b_s;
        cos_v = tab_a_s;
      end
      default: begin
        sin_v = tab_a_s;
        cos_v = tab_b_s;
      end
    endcase
  end

  // Bounds are the half sizes scaled by the Q1.15 denominator, in doubled units.
  always_comb begin
    rx       = SW'(pxc_q) - SW'(pys_q);
    ry       = SW'(pyc_q) + SW'(pxs_q);
    lim_x    = $signed(SW'(w4_q)) <<< SIN_W;
    lim_y    = $signed(SW'(h4_q)) <<< SIN_W;
    inside_d = (rx > -lim_x) && (rx <= lim_x) && (ry > -lim_y) && (ry <= lim_y);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      left0_q <= req_i.rect_left;
      top0_q  <= req_i.rect_top;
      w0_q    <= req_i.rect_width;
      h0_q    <= req_i.rect_height;
      ang0_q  <= req_i.rotation_angle;
      px0_q   <= req_i.point_x;
      py0_q   <= req_i.point_y;
    end
    if (adv[1]) begin
      q1_q   <= q1_d;
      ang1_q <= ang0_q;
      dx1_q  <= dx1_d;
      dy1_q  <= dy1_d;
      w1_q   <= w0_q;
      h1_q   <= h0_q;
    end
    if (adv[2]) begin
      rem2_q  <= rem2_d;
      quad2_q <= quad_e'(qfix[1:0]);
      dx2_q   <= dx1_q;
      dy2_q   <= dy1_q;
      w2_q    <= w1_q;
      h2_q    <= h1_q;
    end
    if (adv[3]) begin
      quad3_q <= quad2_q;
      dx3_q   <= dx2_q;
      dy3_q   <= dy2_q;
      w3_q    <= w2_q;
      h3_q    <= h2_q;
    end
    if (adv[4]) begin
      pxc_q <= PW'(dx3_q) * PW'(cos_v);
      pys_q <= PW'(dy3_q) * PW'(sin_v);
      pyc_q <= PW'(dy3_q) * PW'(cos_v);
      pxs_q <= PW'(dx3_q) * PW'(sin_v);
      w4_q  <= w3_q;
      h4_q  <= h3_q;
    end
    if (adv[5]) begin
      inside_q <= inside_d;
    end
  end

  assign res_o.valid      = vld_q[NStage-1];
  assign res_o.inside_res = inside_q;

endmodule

`default_nettype wire

// File: sv/rrh_sin_rom.sv
`default_nettype none

module rrh_sin_rom #(
  parameter int unsigned ANGLE_STEPS_PER_DEGREE = 16
) (
  input  logic                                               clk_i,
  input  logic                                               en_i,
  input  logic [$clog2(90*ANGLE_STEPS_PER_DEGREE+1)-1:0]     addr_a_i,
  input  logic [$clog2(90*ANGLE_STEPS_PER_DEGREE+1)-1:0]     addr_b_i,
  output logic [rrh_pkg::SIN_W-1:0]                          data_a_o,
  output logic [rrh_pkg::SIN_W-1:0]                          data_b_o
);
  import rrh_pkg::*;

  localparam int unsigned Depth   = 90 * ANGLE_STEPS_PER_DEGREE + 1;
  // One angle step in Q60 radians, split into quotient and remainder so each
  // entry's angle is exact to the last bit.
  localparam logic [63:0] StepDen = 64'(180 * ANGLE_STEPS_PER_DEGREE);
  localparam logic [63:0] StepQuo = PI_Q60 / StepDen;
  localparam logic [63:0] StepRmd = PI_Q60 % StepDen;

  logic [SIN_W-1:0] rom [Depth];
  logic [SIN_W-1:0] data_a_q;
  logic [SIN_W-1:0] data_b_q;

  for (genvar k = 0; k < Depth; k++) begin : g_entry
    localparam logic [63:0] Theta =
        StepQuo * 64'(k) + (StepRmd * 64'(k)) / StepDen;
    localparam logic [SIN_W-1:0] Value = sin_q15(Theta);
    assign rom[k] = Value;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_q <= rom[addr_a_i];
      data_b_q <= rom[addr_b_i];
    end
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

`default_nettype wire

// File: tb/tb_rotated_rect_point_hit_test_unit.sv
`default_nettype none

module tb_rotated_rect_point_hit_test_unit;
  import rrh_pkg::*;

  localparam int unsigned COORD_W     = 24;
  localparam int unsigned STEPS       = 16;
  localparam int unsigned QTURN       = 90 * STEPS;
  localparam int unsigned FULL_TURN   = 4 * QTURN;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct {
    logic signed [COORD_W-1:0] rect_left;
    logic signed [COORD_W-1:0] rect_top;
    logic        [COORD_W-2:0] rect_width;
    logic        [COORD_W-2:0] rect_height;
    logic        [ANGLE_W-1:0] rotation_angle;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } hit_req_t;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SPARSE,
    IDLE_FULL
  } idle_mode_e;

  class hit_scoreboard;
    int  sine_q15 [0:QTURN];
    bit  inside_q [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned inside_seen;

    function new();
      mismatches  = 0;
      checked     = 0;
      inside_seen = 0;
      build_sine();
    endfunction

    function logic [63:0] q60_product(logic [63:0] a, logic [63:0] b);
      return 64'(({64'd0, a} * {64'd0, b}) >> 60);
    endfunction

    // Quarter-wave table of round(32767*sin), summed as a Taylor series in Q60.
    function void build_sine();
      logic [63:0] step_den;
      logic [63:0] whole;
      logic [63:0] frac;
      logic [63:0] theta;
      logic [63:0] theta_sq;
      logic [63:0] term;
      logic [63:0] acc;
      step_den = 64'(180 * STEPS);
      whole    = PI_Q60 / step_den;
      frac     = PI_Q60 % step_den;
      for (int k = 0; k <= QTURN; k++) begin
        theta    = whole * 64'(k) + (frac * 64'(k)) / step_den;
        theta_sq = q60_product(theta, theta);
        term     = theta;
        acc      = theta;
        for (int n = 1; n < 40 && term != 64'd0; n++) begin
          term = q60_product(term, theta_sq) / 64'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) begin
            acc = acc - term;
          end else begin
            acc = acc + term;
          end
        end
        sine_q15[k] = int'(((acc >> 16) * 64'd32767 + (64'd1 << 43)) >> 44);
      end
    endfunction

    // Offsets are taken in doubled units so the center stays an integer and
    // the whole test is exact in 64 bits.
    function bit predict_inside(hit_req_t r);
      longint      left;
      longint      top;
      longint      wd;
      longint      ht;
      longint      dx;
      longint      dy;
      longint      rx;
      longint      ry;
      longint      s;
      longint      c;
      int unsigned ang;
      int unsigned rem;
      quad_e       quad;
      left = longint'(r.rect_left);
      top  = longint'(r.rect_top);
      wd   = longint'({1'b0, r.rect_width});
      ht   = longint'({1'b0, r.rect_height});
      ang  = int'(r.rotation_angle) % FULL_TURN;
      quad = quad_e'(ang / QTURN);
      rem  = ang % QTURN;
      case (quad)
        QUAD_0: begin
          s = sine_q15[rem];
          c = sine_q15[QTURN-rem];
        end
        QUAD_1: begin
          s = sine_q15[QTURN-rem];
          c = -sine_q15[rem];
        end
        QUAD_2: begin
          s = -sine_q15[rem];
          c = -sine_q15[QTURN-rem];
        end
        default: begin
          s = -sine_q15[QTURN-rem];
          c = sine_q15[rem];
        end
      endcase
      dx = 2 * longint'(r.point_x) - 2 * left - wd;
      dy = 2 * longint'(r.point_y) - 2 * top - ht;
      rx = dx * c - dy * s;
      ry = dy * c + dx * s;
      return (rx > -wd * 32768) && (rx <= wd * 32768) &&
             (ry > -ht * 32768) && (ry <= ht * 32768);
    endfunction

    function void note_request(hit_req_t r);
      inside_q.push_back(predict_inside(r));
    endfunction

    function void check_result(logic got);
      bit want;
      if (inside_q.size() == 0) begin
        $error("inside_res: no result expected, actual %0b", got);
        mismatches++;
      end else begin
        want = inside_q.pop_front();
        if (got !== want) begin
          $error("inside_res mismatch: expected %0b, actual %0b", want, got);
          mismatches++;
        end
        checked++;
        if (got === 1'b1) begin
          inside_seen++;
        end
      end
    endfunction

    function int unsigned pending();
      return inside_q.size();
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  hit_scoreboard sb;
  idle_mode_e    idle_mode;
  bit            hold_request;

  rrh_req_if #(.COORD_WIDTH(COORD_W)) req_if ();
  rrh_res_if res_if ();

  rotated_rect_point_hit_test_unit #(
    .COORD_WIDTH           (COORD_W),
    .ANGLE_STEPS_PER_DEGREE(STEPS)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .res_o (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int unsigned idle_cycles();
    case (idle_mode)
      IDLE_NONE:   return 0;
      IDLE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
      default:     return $urandom_range(0, 16);
    endcase
  endfunction

  function automatic hit_req_t make_req(longint left, longint top, longint wd, longint ht,
                                        longint ang, longint px, longint py);
    hit_req_t r;
    r.rect_left      = 24'(left);
    r.rect_top       = 24'(top);
    r.rect_width     = 23'(wd);
    r.rect_height    = 23'(ht);
    r.rotation_angle = 13'(ang);
    r.point_x        = 24'(px);
    r.point_y        = 24'(py);
    return r;
  endfunction

  // Mostly rectangles with the point drawn near them, so both outcomes show
  // up; the rest are axis-aligned edge probes and raw random bits.
  function automatic hit_req_t random_req();
    int unsigned sel;
    longint      left;
    longint      top;
    longint      wd;
    longint      ht;
    longint      ang;
    longint      span;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      return make_req($urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom_range(0, 8191), $urandom(), $urandom());
    end
    left = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
    top  = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
    if (sel < 4) begin
      wd  = $urandom_range(0, 1024);
      ht  = $urandom_range(0, 1024);
      ang = QTURN * $urandom_range(0, 3);
      return make_req(left, top, wd, ht, ang,
                      left + longint'($urandom_range(0, wd + 2)) - 1,
                      top + longint'($urandom_range(0, ht + 2)) - 1);
    end
    if ($urandom_range(0, 15) == 0) begin
      wd = $urandom_range(0, 8388607);
      ht = $urandom_range(0, 8388607);
    end else begin
      wd = $urandom_range(0, 1 << 16);
      ht = $urandom_range(0, 1 << 16);
    end
    ang  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 5759);
    span = (wd > ht) ? wd : ht;
    return make_req(left, top, wd, ht, ang,
                    left + wd / 2 + longint'($urandom_range(0, 2 * span)) - span,
                    top + ht / 2 + longint'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic drive_request(input hit_req_t r);
    int unsigned gap;
    gap = idle_cycles();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid          <= 1'b1;
    req_if.rect_left      <= r.rect_left;
    req_if.rect_top       <= r.rect_top;
    req_if.rect_width     <= r.rect_width;
    req_if.rect_height    <= r.rect_height;
    req_if.rotation_angle <= r.rotation_angle;
    req_if.point_x        <= r.point_x;
    req_if.point_y        <= r.point_y;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    sb.note_request(r);
  endtask

  task automatic drive_random(input int unsigned count);
    repeat (count) drive_request(random_req());
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned stall;
    res_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall        = HOLD_CYCLES;
      end else begin
        stall = idle_cycles();
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (res_if.valid !== 1'b1);
      sb.check_result(res_if.inside_res);
    end
  end

  initial begin
    sb                    = new();
    idle_mode             = IDLE_FULL;
    hold_request          = 1'b0;
    rst_n                 <= 1'b0;
    req_if.valid          <= 1'b0;
    req_if.rect_left      <= '0;
    req_if.rect_top       <= '0;
    req_if.rect_width     <= '0;
    req_if.rect_height    <= '0;
    req_if.rotation_angle <= '0;
    req_if.point_x        <= '0;
    req_if.point_y        <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Center, empty rectangles and every edge with no rotation.
    drive_request(make_req(0, 0, 4096, 4096, 0, 2048, 2048));
    drive_request(make_req(0, 0, 0, 4096, 0, 0, 2048));
    drive_request(make_req(0, 0, 4096, 0, 0, 2048, 0));
    drive_request(make_req(0, 0, 4096, 4096, 0, 0, 2048));
    drive_request(make_req(0, 0, 4096, 4096, 0, 4096, 2048));
    drive_request(make_req(0, 0, 4096, 4096, 0, 4097, 2048));
    drive_request(make_req(0, 0, 4096, 4096, 0, 2048, 0));
    drive_request(make_req(0, 0, 4096, 4096, 0, 2048, 4096));
    drive_request(make_req(0, 0, 4096, 4096, 0, 2048, 4097));
    // Quadrant boundaries and angles past a full turn.
    drive_request(make_req(-1000, -1000, 8192, 1024, QTURN, 3096, 2000));
    drive_request(make_req(-1000, -1000, 8192, 1024, 2 * QTURN, 3096, -490));
    drive_request(make_req(-1000, -1000, 8192, 1024, 3 * QTURN, 3096, 2000));
    drive_request(make_req(500, 700, 2048, 2048, FULL_TURN - 1, 2547, 1723));
    drive_request(make_req(500, 700, 2048, 2048, FULL_TURN, 500, 1723));
    drive_request(make_req(500, 700, 2048, 2048, 8191, 1524, 1500));
    drive_request(make_req(500, 700, 2048, 2048, 4096, 1524, 1723));
    drive_request(make_req(0, 0, 4096, 4096, 720, 4096, 4096));
    drive_request(make_req(0, 0, 4096, 4096, 720, 3000, 2048));
    // Field extremes.
    drive_request(make_req(-8388608, -8388608, 8388607, 8388607, 0, 8388607, 8388607));
    drive_request(make_req(8388607, 8388607, 8388607, 8388607, 8191, 8388607, 8388607));
    drive_request(make_req(-8388608, -8388608, 0, 0, 0, -8388608, -8388608));
    drive_request(make_req(0, 0, 4096, 4096, 720, -8388608, 8388607));
    drive_request(make_req(-8388608, 8388607, 8388607, 1, 2 * QTURN, 0, 8388607));

    drive_random(150);
    req_if.valid <= 1'b0;
    wait_drained();

    idle_mode = IDLE_NONE;
    drive_random(100);

    // Hold results back long enough for the pipeline to fill and stall input.
    hold_request = 1'b1;
    drive_random(60);
    req_if.valid <= 1'b0;
    wait_drained();

    idle_mode = IDLE_SPARSE;
    drive_random(120);
    req_if.valid <= 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Checked %0d hit tests (%0d inside, %0d outside) across all quadrants,",
             sb.checked, sb.inside_seen, sb.checked - sb.inside_seen);
    $display("wrapped angles, edges, field extremes, idle gaps and a long output stall.");
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
sv/rrh_pkg.sv
sv/rrh_req_if.sv
sv/rrh_res_if.sv
sv/rrh_sin_rom.sv
sv/rotated_rect_point_hit_test_unit.sv
tb/tb_rotated_rect_point_hit_test_unit.sv
